>>> sv/psra_pkg.sv
package psra_pkg;

    localparam int unsigned ECHO_W  = 15;
    localparam int unsigned NOW_W   = 32;
    localparam int unsigned DIST_W  = 18;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned GAP_W   = 10;

    // register indexes on the configuration port
    localparam logic REG_LOWER_LIMIT = 1'b0;
    localparam logic REG_UPPER_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 7'd10;
    localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 7'd20;

    // distance calibration: (echo * DIST_MUL >> 16) + DIST_OFS, in 1/256 cm
    localparam logic [18:0]       DIST_MUL = 19'd293398;
    localparam logic [DIST_W-1:0] DIST_OFS = 18'd230;

    localparam logic [DIST_W-1:0] NEAR_Q8 = 18'd1280;   // 5 cm
    localparam logic [DIST_W-1:0] FAR_Q8  = 18'd5120;   // 20 cm
    localparam logic [4:0]        NEAR_CM = 5'd5;
    localparam logic [GAP_W-1:0]  BEEP_MS = 10'd100;

    typedef struct packed {
        logic [DIST_W-1:0] dist_q8;
        logic              far;
        logic              near;
    } dist_info_t;

    // gap = 100 + k * 500 / 15, k = cm - 5 in 0..15
    function automatic logic [GAP_W-1:0] gap_ms(input logic [3:0] k);
        logic [GAP_W-1:0] g;
        unique case (k)
            4'd0:  g = 10'd100;
            4'd1:  g = 10'd133;
            4'd2:  g = 10'd166;
            4'd3:  g = 10'd200;
            4'd4:  g = 10'd233;
            4'd5:  g = 10'd266;
            4'd6:  g = 10'd300;
            4'd7:  g = 10'd333;
            4'd8:  g = 10'd366;
            4'd9:  g = 10'd400;
            4'd10: g = 10'd433;
            4'd11: g = 10'd466;
            4'd12: g = 10'd500;
            4'd13: g = 10'd533;
            4'd14: g = 10'd566;
            4'd15: g = 10'd600;
        endcase
        return g;
    endfunction

endpackage

>>> sv/psra_dist.sv
module psra_dist import psra_pkg::*; #(
    parameter int unsigned ECHO_TIMEOUT_US = 30000
) (
    input  logic [ECHO_W-1:0] echo_us,
    output dist_info_t        info
);

    logic [ECHO_W-1:0] echo_eff;
    logic [33:0]       prod;
    logic [DIST_W-1:0] dist_sum;

    // echo past timeout counts as no echo
    assign echo_eff = ({1'b0, echo_us} > 16'(ECHO_TIMEOUT_US)) ? '0 : echo_us;
    assign prod     = 34'(echo_eff) * 34'(DIST_MUL);
    assign dist_sum = prod[33:16] + DIST_OFS;

    assign info.dist_q8 = dist_sum;
    assign info.far     = dist_sum > FAR_Q8;
    assign info.near    = dist_sum <= NEAR_Q8;

endmodule

>>> sv/psra_window.sv
module psra_window import psra_pkg::*; (
    input  logic [DIST_W-1:0]  dist_q8,
    input  logic [LIMIT_W-1:0] lower_limit,
    input  logic [LIMIT_W-1:0] upper_limit,
    output logic               led_low,
    output logic               led_high
);

    logic [LIMIT_W:0]  eff_upper;
    logic [DIST_W-1:0] lower_q8;
    logic [DIST_W-1:0] upper_q8;

    // inverted window: upper follows lower + 5
    assign eff_upper = (upper_limit < lower_limit) ? ({1'b0, lower_limit} + 8'd5)
                                                   : {1'b0, upper_limit};
    assign lower_q8  = {3'b0, lower_limit, 8'b0};
    assign upper_q8  = {2'b0, eff_upper, 8'b0};

    assign led_low  = dist_q8 < lower_q8;
    assign led_high = !led_low && (dist_q8 > upper_q8);

endmodule

>>> sv/psra_beep.sv
module psra_beep import psra_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  dist_info_t       info,
    input  logic [NOW_W-1:0] now_ms,
    output logic             tone_next
);

    logic [NOW_W-1:0] last_beep_reg, last_beep_next;
    logic             active_reg, active_next;
    logic             tone_reg;
    logic [NOW_W-1:0] elapsed;
    logic [GAP_W-1:0] gap;
    logic [4:0]       cm;

    assign cm      = info.dist_q8[12:8];
    assign gap     = gap_ms(4'(cm - NEAR_CM));
    assign elapsed = now_ms - last_beep_reg;   // wraps mod 2^32

    always_comb begin
        tone_next      = tone_reg;
        active_next    = active_reg;
        last_beep_next = last_beep_reg;
        priority if (info.far) begin
            tone_next   = 1'b0;
            active_next = 1'b0;
        end else if (info.near) begin
            tone_next = 1'b1;
        end else begin
            priority if (!active_reg && elapsed >= 32'(gap)) begin
                tone_next      = 1'b1;
                active_next    = 1'b1;
                last_beep_next = now_ms;
            end else if (active_reg && elapsed >= 32'(BEEP_MS)) begin
                tone_next   = 1'b0;
                active_next = 1'b0;
            end else begin
                tone_next = tone_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_reg      <= 1'b0;
            active_reg    <= 1'b0;
            last_beep_reg <= '0;
        end else if (step_en) begin
            tone_reg      <= tone_next;
            active_reg    <= active_next;
            last_beep_reg <= last_beep_next;
        end
    end

endmodule

>>> sv/parking_sensor_range_alarm.sv
// A request passes from the input register to the result register, where it
// shows on m_tvalid until the receiver takes it with m_tready.
// Throughput: one request per cycle, sustained, while m_tready stays high.
// Reset: aresetn synchronous, active low; clears both stages, the beeper
// state (buzzer off, no beep, last beep at 0) and sets limits to 10 / 20 cm.
module parking_sensor_range_alarm import psra_pkg::*; #(
    parameter int unsigned ECHO_TIMEOUT_US = 30000
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,    // echo_us[14:0], now_ms[46:15], pad

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,    // distance_q8[17:0], led_low[18],
                                           // led_high[19], buzzer_on[20], pad

    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    // ---- configuration registers ----
    logic [LIMIT_W-1:0] lower_reg;
    logic [LIMIT_W-1:0] upper_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= LOWER_LIMIT_RST;
            upper_reg <= UPPER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LOWER_LIMIT: lower_reg <= cfg_wdata;
                REG_UPPER_LIMIT: upper_reg <= cfg_wdata;
            endcase
        end
    end

    // ---- handshake: two-entry pipe, each stage moves when the next frees ----
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic step_en;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign step_en  = in_valid_reg && out_adv;   // request moves to result reg

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    // ---- input register ----
    logic [ECHO_W-1:0] echo_reg;
    logic [NOW_W-1:0]  now_reg;

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            echo_reg <= s_tdata[14:0];
            now_reg  <= s_tdata[46:15];
        end
    end

    // ---- single pass: distance, window, beeper ----
    dist_info_t info;
    logic       led_low;
    logic       led_high;
    logic       tone_next;

    psra_dist #(
        .ECHO_TIMEOUT_US(ECHO_TIMEOUT_US)
    ) u_dist (
        .echo_us (echo_reg),
        .info    (info)
    );

    psra_window u_window (
        .dist_q8     (info.dist_q8),
        .lower_limit (lower_reg),
        .upper_limit (upper_reg),
        .led_low     (led_low),
        .led_high    (led_high)
    );

    // beeper state advances only when a request leaves the input register
    psra_beep u_beep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .info      (info),
        .now_ms    (now_reg),
        .tone_next (tone_next)
    );

    // ---- result register ----
    logic [DIST_W-1:0] dist_reg;
    logic              led_low_reg;
    logic              led_high_reg;
    logic              buzzer_reg;
    logic              far_reg;
    logic              near_reg;

    always_ff @(posedge aclk) begin
        if (step_en) begin
            dist_reg     <= info.dist_q8;
            led_low_reg  <= led_low;
            led_high_reg <= led_high;
            buzzer_reg   <= tone_next;
            far_reg      <= info.far;
            near_reg     <= info.near;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, buzzer_reg, led_high_reg, led_low_reg, dist_reg};

    // ---- checks ----
    // beyond 20 cm the buzzer must be silent
    a_far_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && far_reg) |-> !buzzer_reg)
        else $error("buzzer sounding in off zone");

    // at 5 cm or less the buzzer must sound
    a_near_sound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && near_reg) |-> buzzer_reg)
        else $error("buzzer silent in continuous zone");

    // window LEDs never both lit
    a_led_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(led_low_reg && led_high_reg))
        else $error("both window LEDs lit");

    // a stalled result keeps the input stage from being overwritten
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_adv) |=> (in_valid_reg && $stable(echo_reg)
                                        && $stable(now_reg)))
        else $error("input stage lost a pending request");

endmodule

>>> bench/parking_sensor_range_alarm_checker.sv
module parking_sensor_range_alarm_checker import psra_pkg::*; #(
    parameter int unsigned ECHO_TIMEOUT_US = 30000
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [47:0]        s_tdata,    // echo_us[14:0], now_ms[46:15], pad
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [23:0]        m_tdata,    // distance_q8[17:0], led_low[18],
                                           // led_high[19], buzzer_on[20], pad
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    output int unsigned        mismatches,
    output int unsigned        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] CAL_MUL      = 48'd293398;
    localparam int unsigned CAL_OFS      = 230;
    localparam int unsigned NEAR_DIST_Q8 = 5 * 256;
    localparam int unsigned FAR_DIST_Q8  = 20 * 256;
    localparam int unsigned BEEP_LEN_MS  = 100;

    typedef struct packed {
        logic [DIST_W-1:0] dist_q8;
        logic              led_low;
        logic              led_high;
        logic              buzzer_on;
    } alarm_t;

    logic [LIMIT_W-1:0] lower_cm;
    logic [LIMIT_W-1:0] upper_cm;
    logic [NOW_W-1:0]   beep_start_ms;
    logic               beeping;
    logic               tone;
    alarm_t             pending_alarms[$];

    // distance, window LEDs and beeper step; updates the beeper state
    function automatic alarm_t predict_alarm(input logic [ECHO_W-1:0] echo,
                                             input logic [NOW_W-1:0]  now);
        alarm_t           r;
        logic [47:0]      scaled;
        int unsigned      dist_val;
        int unsigned      eff_upper;
        int unsigned      cm;
        int unsigned      gap;
        logic [NOW_W-1:0] elapsed;
        if (echo > ECHO_TIMEOUT_US)
            echo = '0;
        scaled = 48'(echo) * CAL_MUL;
        dist_val = int'(scaled >> 16) + CAL_OFS;
        r.dist_q8 = DIST_W'(dist_val);
        eff_upper = (upper_cm < lower_cm) ? int'(lower_cm) + 5 : int'(upper_cm);
        r.led_low  = dist_val < int'(lower_cm) * 256;
        r.led_high = !r.led_low && (dist_val > eff_upper * 256);
        if (dist_val > FAR_DIST_Q8) begin
            tone = 1'b0;
            beeping = 1'b0;
        end else if (dist_val <= NEAR_DIST_Q8) begin
            tone = 1'b1;
        end else begin
            cm = dist_val >> 8;
            gap = 100 + (cm - 5) * 500 / 15;
            elapsed = now - beep_start_ms;
            if (!beeping && elapsed >= gap) begin
                tone = 1'b1;
                beeping = 1'b1;
                beep_start_ms = now;
            end else if (beeping && elapsed >= BEEP_LEN_MS) begin
                tone = 1'b0;
                beeping = 1'b0;
            end
        end
        r.buzzer_on = tone;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        alarm_t      got;
        alarm_t      want;
        int unsigned errs;
        errs = 0;
        if (!aresetn) begin
            lower_cm = LOWER_LIMIT_RST;
            upper_cm = UPPER_LIMIT_RST;
            beep_start_ms = '0;
            beeping = 1'b0;
            tone = 1'b0;
            pending_alarms.delete();
            mismatches <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOWER_LIMIT: lower_cm = cfg_wdata;
                    REG_UPPER_LIMIT: upper_cm = cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[17:0], m_tdata[18], m_tdata[19], m_tdata[20]};
                if (pending_alarms.size() == 0) begin
                    $display("%0t: result with nothing pending, got %h", $time, m_tdata);
                    errs++;
                end else begin
                    want = pending_alarms.pop_front();
                    if (got.dist_q8 !== want.dist_q8) begin
                        $display("%0t: distance_q8 expected %0d got %0d",
                                 $time, want.dist_q8, got.dist_q8);
                        errs++;
                    end
                    if (got.led_low !== want.led_low) begin
                        $display("%0t: led_low expected %b got %b",
                                 $time, want.led_low, got.led_low);
                        errs++;
                    end
                    if (got.led_high !== want.led_high) begin
                        $display("%0t: led_high expected %b got %b",
                                 $time, want.led_high, got.led_high);
                        errs++;
                    end
                    if (got.buzzer_on !== want.buzzer_on) begin
                        $display("%0t: buzzer_on expected %b got %b",
                                 $time, want.buzzer_on, got.buzzer_on);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_alarms.push_back(predict_alarm(s_tdata[14:0], s_tdata[46:15]));
            mismatches <= mismatches + errs;
            outstanding <= pending_alarms.size();
        end
    end

endmodule

>>> bench/parking_sensor_range_alarm_tb.sv
module parking_sensor_range_alarm_tb;
    import psra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TIMEOUT_US       = 30000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;   // receiver blackout
    localparam int unsigned DRAIN_CYCLES     = 8;     // pipeline is 2 deep

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = REG_LOWER_LIMIT;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    int unsigned        mismatches;
    int unsigned        outstanding;

    // running millisecond time base for the requests
    logic [NOW_W-1:0]   clock_ms  = '0;
    // asks the receiver for its one long blackout
    bit                 hold_req  = 1'b0;

    always #1 aclk = ~aclk;

    parking_sensor_range_alarm #(
        .ECHO_TIMEOUT_US(TIMEOUT_US)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    parking_sensor_range_alarm_checker #(
        .ECHO_TIMEOUT_US(TIMEOUT_US)
    ) alarm_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: segments of always-ready, coin-flip ready and short stalls.
    // Once the stimulus raises hold_req it drops ready for a long stretch so
    // the block backs up and stalls the request side.
    initial begin : receiver
        int unsigned seg_left;
        int unsigned seg_mode;
        int unsigned hold_left;
        bit          hold_done;
        seg_left  = 0;
        seg_mode  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = (seg_mode == 2) ? $urandom_range(1, 6)
                                               : $urandom_range(4, 60);
                end
                seg_left--;
                case (seg_mode)
                    2:       m_tready <= 1'b0;
                    3:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // present one request and hold it until the handshake edge
    task automatic offer(input logic [ECHO_W-1:0] echo, input logic [NOW_W-1:0] now);
        s_tdata  <= {1'b0, now, echo};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop sending and wait for every pending result, plus pipeline slack
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // both limit registers, back to back; only called with the block idle
    task automatic set_limits(input int unsigned lo, input int unsigned up);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LOWER_LIMIT;
        cfg_wdata <= LIMIT_W'(lo);
        @(posedge aclk);
        cfg_index <= REG_UPPER_LIMIT;
        cfg_wdata <= LIMIT_W'(up);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly plausible parking sequences: echoes around the beeper zones and
    // time moving forward by steps comparable to beep and gap lengths. The
    // rest is any echo width, time stepping further or jumping anywhere (wrap included).
    task automatic random_items(input int unsigned n);
        int unsigned       burst_left;
        int unsigned       kind;
        logic [ECHO_W-1:0] echo;
        burst_left = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                // roughly one burst in four follows straight on, no gap
                if ($urandom_range(0, 3) != 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge aclk);
                end
            end
            burst_left--;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                echo = ECHO_W'($urandom_range(0, 1300));
                clock_ms += $urandom_range(0, 250);
            end else if (kind < 85) begin
                echo = ECHO_W'($urandom_range(0, 32767));
                clock_ms += $urandom_range(0, 700);
            end else begin
                echo = ECHO_W'($urandom_range(0, 32767));
                clock_ms = $urandom();
            end
            offer(echo, clock_ms);
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset limits 10 / 20 cm
        offer(15'd0,     32'd0);      // timeout echo: about 0.9 cm, tone on
        offer(15'd32767, 32'd5);      // beyond timeout, treated as timeout
        offer(15'd30001, 32'd10);
        offer(15'd30000, 32'd15);     // longest valid echo: off zone
        offer(15'd1,     32'd20);
        offer(15'd234,   32'd25);     // last echo in the continuous zone
        offer(15'd235,   32'd30);     // beep zone, tone carried over
        offer(15'd235,   32'd200);    // gap elapsed: beep starts
        offer(15'd235,   32'd250);    // beep still running
        offer(15'd235,   32'd300);    // 100 ms: beep ends
        offer(15'd235,   32'd350);    // gap reached again: next beep starts
        offer(15'd1092,  32'd400);    // top of the beep zone
        offer(15'd1093,  32'd450);    // just past 20 cm
        offer(15'd1092,  32'd1000);
        offer(15'd700,   32'd1100);
        offer(15'd700,   32'hFFFF_FF00);
        offer(15'd700,   32'h0000_0010);  // elapsed across the time wrap
        offer(15'd700,   32'h0000_0020);
        offer(15'h5555,  32'hAAAA_AAAA);
        offer(15'h2AAA,  32'h5555_5555);
        offer(15'h4000,  32'hFFFF_FFFF);
        clock_ms = 32'd2000;
        random_items(180);
        drain();

        // limit extremes, including values outside the nominal range and
        // upper below lower (effective upper becomes lower + 5)
        set_limits(2, 100);
        random_items(180);
        drain();

        set_limits(100, 2);
        hold_req = 1'b1;
        random_items(180);
        drain();

        set_limits(0, 127);
        random_items(150);
        drain();

        set_limits(127, 0);
        random_items(150);
        drain();

        set_limits(1, 1);
        random_items(120);
        drain();

        repeat (3) begin
            set_limits($urandom_range(2, 100), $urandom_range(2, 100));
            random_items(110);
            drain();
        end

        if (mismatches == 0)
            $display("parking_sensor_range_alarm verification clean");
        else
            $display("parking_sensor_range_alarm verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("parking_sensor_range_alarm verification failed");
        $finish;
    end

endmodule
